@@ rtl/tdca_pkg.sv @@
package tdca_pkg;

	// default frame geometry
	localparam int unsigned FRAME_WIDTH_DEF  = 640;
	localparam int unsigned FRAME_HEIGHT_DEF = 480;

	// field widths
	localparam int unsigned DEPTH_W  = 16;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned COLOR_W  = 3 * CHAN_W;
	localparam int unsigned WEIGHT_W = 17;
	localparam int unsigned STEP_W   = 3;
	localparam int unsigned PIX_X_W  = 10;
	localparam int unsigned PIX_Y_W  = 9;
	localparam int unsigned REG_IDX_W = 2;

	// unity weight in q1.16
	localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

	// register reset values
	localparam logic [WEIGHT_W-1:0] DEPTH_WEIGHT_RST    = 17'd32768;
	localparam logic [WEIGHT_W-1:0] COLOR_WEIGHT_RST    = 17'd32768;
	localparam logic [DEPTH_W-1:0]  VALID_THRESHOLD_RST = 16'd8;
	localparam logic [STEP_W-1:0]   SAMPLE_STEP_RST     = 3'd0;

	typedef enum logic [1:0] {
		REQ_BLEND     = 2'd0,
		REQ_OVERWRITE = 2'd1,
		REQ_READ      = 2'd2
	} req_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEPTH_WEIGHT    = 2'd0,
		REG_COLOR_WEIGHT    = 2'd1,
		REG_VALID_THRESHOLD = 2'd2,
		REG_SAMPLE_STEP     = 2'd3
	} reg_idx_t;

	// live configuration, weights already clamped to one
	typedef struct packed {
		logic [WEIGHT_W-1:0] depth_weight;
		logic [WEIGHT_W-1:0] color_weight;
		logic [DEPTH_W-1:0]  valid_threshold;
		logic [STEP_W-1:0]   sample_step_log2;
	} cfg_t;

	// per-word request controls
	typedef struct packed {
		logic [1:0] req_type;
		logic       apply_depth;
		logic       apply_color;
	} req_ctl_t;

endpackage

@@ rtl/tdca_store.sv @@
module tdca_store #(
	parameter int unsigned DEPTH  = tdca_pkg::FRAME_WIDTH_DEF * tdca_pkg::FRAME_HEIGHT_DEF,
	parameter int unsigned ADDR_W = 19,
	parameter int unsigned DATA_W = tdca_pkg::DEPTH_W + tdca_pkg::COLOR_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	// depth and color share one word per pixel
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read returns the contents before a same-edge write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/tdca_mix.sv @@
module tdca_mix (
	input  tdca_pkg::cfg_t                     cfg,
	input  tdca_pkg::req_ctl_t                 ctl,
	input  logic [tdca_pkg::DEPTH_W-1:0]       old_depth,
	input  logic [tdca_pkg::COLOR_W-1:0]       old_color,
	input  logic [tdca_pkg::DEPTH_W-1:0]       new_depth,
	input  logic [tdca_pkg::COLOR_W-1:0]       new_color,
	output logic [tdca_pkg::DEPTH_W-1:0]       depth_out,
	output logic [tdca_pkg::COLOR_W-1:0]       color_out
);

	// (o*w + n*(1-w)) >> 16 rewritten as n + floor((o-n)*w / 65536)
	function automatic logic [15:0] mix_depth(
		input logic [15:0] o,
		input logic [15:0] n,
		input logic [16:0] w
	);
		logic signed [16:0] diff;
		logic signed [34:0] prod;
		logic signed [34:0] sum;
		diff = $signed({1'b0, o}) - $signed({1'b0, n});
		prod = diff * $signed({1'b0, w});
		sum  = (prod >>> 16) + $signed({19'd0, n});
		return sum[15:0];
	endfunction

	function automatic logic [7:0] mix_chan(
		input logic [7:0]  o,
		input logic [7:0]  n,
		input logic [16:0] w
	);
		logic signed [8:0]  diff;
		logic signed [26:0] prod;
		logic signed [26:0] sum;
		diff = $signed({1'b0, o}) - $signed({1'b0, n});
		prod = diff * $signed({1'b0, w});
		sum  = (prod >>> 16) + $signed({19'd0, n});
		return sum[7:0];
	endfunction

	localparam int unsigned CW = tdca_pkg::CHAN_W;

	logic [tdca_pkg::COLOR_W-1:0] blend_color;
	logic                         depth_valid;

	assign depth_valid = new_depth > cfg.valid_threshold;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			blend_color[k*CW +: CW] = mix_chan(old_color[k*CW +: CW],
				new_color[k*CW +: CW], cfg.color_weight);
		end
	end

	always_comb begin
		depth_out = old_depth;
		color_out = old_color;
		unique case (tdca_pkg::req_t'(ctl.req_type))
			tdca_pkg::REQ_BLEND: begin
				if (ctl.apply_depth && depth_valid) begin
					// empty pixel takes the new sample as is
					if (old_depth <= cfg.valid_threshold) begin
						depth_out = new_depth;
					end else begin
						depth_out = mix_depth(old_depth, new_depth, cfg.depth_weight);
					end
				end
				if (ctl.apply_color) begin
					color_out = blend_color;
				end
			end
			tdca_pkg::REQ_OVERWRITE: begin
				if (ctl.apply_depth) begin
					depth_out = new_depth;
				end
				if (ctl.apply_color) begin
					color_out = new_color;
				end
			end
			default: begin
				// read only, code three included
				depth_out = old_depth;
				color_out = old_color;
			end
		endcase
	end

endmodule

@@ rtl/temporal_depth_color_averager_core.sv @@
// per-pixel running average of a depth frame and an rgb frame
//
// input word: start high with busy low accepts one pixel request (req_type,
// pixel_x, pixel_y, new_depth, new_red/green/blue, apply_depth, apply_color).
// busy never rises: the pipeline takes a word in every cycle, same pixel
// back to back included, so the sustained rate is one word per clock.
// result word: done is high for exactly one cycle with stored_depth,
// stored_red/green/blue and on_grid; the accepting edge reads the frame
// memory, the next edge writes it back and registers the result. the
// receiver cannot stall, so every result is taken in the cycle it is shown.
// the rate is set by the read-modify-write loop on a memory with one read and
// one write port: the blend of one word feeds the next one through a one-word
// bypass from the result registers, as that word's read sees the old contents.
// pixels outside the frame or off the sampling grid touch nothing and report
// zero with on_grid low.
// configuration: cfg_we, cfg_index and cfg_data write one register per edge;
// write only while no word is in flight. reset (arst_n low) restores the
// register defaults and empties the pipeline; the frame memory is not cleared
// and a pixel must be written before its stored value means anything.
module temporal_depth_color_averager_core #(
	parameter int unsigned FRAME_WIDTH  = tdca_pkg::FRAME_WIDTH_DEF,
	parameter int unsigned FRAME_HEIGHT = tdca_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// configuration write port
	input  logic                                cfg_we,
	input  logic [tdca_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [tdca_pkg::WEIGHT_W-1:0]       cfg_data,

	// request word
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          req_type,
	input  logic [tdca_pkg::PIX_X_W-1:0]        pixel_x,
	input  logic [tdca_pkg::PIX_Y_W-1:0]        pixel_y,
	input  logic [tdca_pkg::DEPTH_W-1:0]        new_depth,
	input  logic [tdca_pkg::CHAN_W-1:0]         new_red,
	input  logic [tdca_pkg::CHAN_W-1:0]         new_green,
	input  logic [tdca_pkg::CHAN_W-1:0]         new_blue,
	input  logic                                apply_depth,
	input  logic                                apply_color,

	// result word
	output logic                                done,
	output logic [tdca_pkg::DEPTH_W-1:0]        stored_depth,
	output logic [tdca_pkg::CHAN_W-1:0]         stored_red,
	output logic [tdca_pkg::CHAN_W-1:0]         stored_green,
	output logic [tdca_pkg::CHAN_W-1:0]         stored_blue,
	output logic                                on_grid
);

	localparam int unsigned PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int unsigned ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
	localparam int unsigned DW        = tdca_pkg::DEPTH_W;
	localparam int unsigned CLW       = tdca_pkg::COLOR_W;
	localparam int unsigned XW        = tdca_pkg::PIX_X_W;

	// ---------------------------------------------------------------
	// configuration registers, weights clamped to one on the way in
	// ---------------------------------------------------------------
	tdca_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_weight     <= tdca_pkg::DEPTH_WEIGHT_RST;
			cfg_q.color_weight     <= tdca_pkg::COLOR_WEIGHT_RST;
			cfg_q.valid_threshold  <= tdca_pkg::VALID_THRESHOLD_RST;
			cfg_q.sample_step_log2 <= tdca_pkg::SAMPLE_STEP_RST;
		end else if (cfg_we) begin
			unique case (tdca_pkg::reg_idx_t'(cfg_index))
				tdca_pkg::REG_DEPTH_WEIGHT: begin
					cfg_q.depth_weight <= (cfg_data > tdca_pkg::ONE_Q16) ?
						tdca_pkg::ONE_Q16 : cfg_data;
				end
				tdca_pkg::REG_COLOR_WEIGHT: begin
					cfg_q.color_weight <= (cfg_data > tdca_pkg::ONE_Q16) ?
						tdca_pkg::ONE_Q16 : cfg_data;
				end
				tdca_pkg::REG_VALID_THRESHOLD: begin
					cfg_q.valid_threshold <= cfg_data[DW-1:0];
				end
				tdca_pkg::REG_SAMPLE_STEP: begin
					cfg_q.sample_step_log2 <= cfg_data[tdca_pkg::STEP_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage 0: accept, frame and grid check, address, memory read
	// ---------------------------------------------------------------
	logic              accept;
	logic              in_frame;
	logic              grid_hit;
	logic              hit_c;
	logic [XW-1:0]     grid_mask;
	logic [ADDR_W-1:0] idx_c;

	// no stall source in this pipeline
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign in_frame = (32'(pixel_x) < 32'(FRAME_WIDTH)) &&
		(32'(pixel_y) < 32'(FRAME_HEIGHT));

	// step 2^n: low n bits of both coordinates must be zero
	assign grid_mask = (XW'(1) << cfg_q.sample_step_log2) - XW'(1);
	assign grid_hit  = ((pixel_x & grid_mask) == '0) &&
		((XW'(pixel_y) & grid_mask) == '0);
	assign hit_c     = in_frame && grid_hit;

	// only meaningful inside the frame, where it cannot overflow
	assign idx_c = ADDR_W'(pixel_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(pixel_x);

	// ---------------------------------------------------------------
	// stage 1 registers
	// ---------------------------------------------------------------
	logic                 valid_s1;
	logic                 hit_s1;
	logic [ADDR_W-1:0]    idx_s1;
	tdca_pkg::req_ctl_t   ctl_s1;
	logic [DW-1:0]        depth_s1;
	logic [CLW-1:0]       color_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			hit_s1   <= accept && hit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1               <= idx_c;
			ctl_s1.req_type      <= req_type;
			ctl_s1.apply_depth   <= apply_depth;
			ctl_s1.apply_color   <= apply_color;
			depth_s1             <= new_depth;
			color_s1             <= {new_red, new_green, new_blue};
		end
	end

	// ---------------------------------------------------------------
	// frame memory: {depth, red, green, blue} per pixel
	// ---------------------------------------------------------------
	logic              mem_we;
	logic [DW+CLW-1:0] mem_wdata;
	logic [DW+CLW-1:0] mem_rdata;

	tdca_store #(
		.DEPTH  (PIX_COUNT),
		.ADDR_W (ADDR_W),
		.DATA_W (DW + CLW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_s1),
		.wdata (mem_wdata),
		.re    (accept && hit_c),
		.raddr (idx_c),
		.rdata (mem_rdata)
	);

	// ---------------------------------------------------------------
	// stage 1: bypass, blend, write back
	// ---------------------------------------------------------------
	logic              wb_hit_q;
	logic [ADDR_W-1:0] wb_idx_q;
	logic              fwd;
	logic [DW-1:0]     old_depth;
	logic [CLW-1:0]    old_color;
	logic [DW-1:0]     upd_depth;
	logic [CLW-1:0]    upd_color;

	logic              done_q;
	logic              on_grid_q;
	logic [DW-1:0]     stored_depth_q;
	logic [CLW-1:0]    stored_color_q;

	// the word written on the edge of our read is not in the read data yet
	assign fwd       = wb_hit_q && (wb_idx_q == idx_s1);
	assign old_depth = fwd ? stored_depth_q : mem_rdata[DW+CLW-1:CLW];
	assign old_color = fwd ? stored_color_q : mem_rdata[CLW-1:0];

	tdca_mix u_mix (
		.cfg       (cfg_q),
		.ctl       (ctl_s1),
		.old_depth (old_depth),
		.old_color (old_color),
		.new_depth (depth_s1),
		.new_color (color_s1),
		.depth_out (upd_depth),
		.color_out (upd_color)
	);

	// read requests write back the unchanged value
	assign mem_we    = valid_s1 && hit_s1;
	assign mem_wdata = {upd_depth, upd_color};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			on_grid_q <= 1'b0;
			wb_hit_q  <= 1'b0;
		end else begin
			done_q    <= valid_s1;
			on_grid_q <= valid_s1 && hit_s1;
			wb_hit_q  <= valid_s1 && hit_s1;
		end
	end

	// result registers double as the bypass source
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			wb_idx_q       <= idx_s1;
			stored_depth_q <= hit_s1 ? upd_depth : '0;
			stored_color_q <= hit_s1 ? upd_color : '0;
		end
	end

	assign done         = done_q;
	assign on_grid      = on_grid_q;
	assign stored_depth = stored_depth_q;
	assign stored_red   = stored_color_q[3*tdca_pkg::CHAN_W-1:2*tdca_pkg::CHAN_W];
	assign stored_green = stored_color_q[2*tdca_pkg::CHAN_W-1:tdca_pkg::CHAN_W];
	assign stored_blue  = stored_color_q[tdca_pkg::CHAN_W-1:0];

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------

	// every accepted word gives exactly one result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted word produced no result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without an accepted word");

	// skipped pixels report all zeros
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !on_grid) |-> (stored_depth == '0 && stored_red == '0 &&
			stored_green == '0 && stored_blue == '0))
		else $error("skipped pixel reported stored values");

	// a memory write only happens for a word in flight on the grid
	a_write_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (done && on_grid))
		else $error("frame write without a matching result");

endmodule
